// ===== rtl/spectral_phase_rotator_assert.svh =====
// Assertion macros for the spectral phase rotator.
// Expects aclk and aresetn in the scope of the module that uses them.
`ifndef SPECTRAL_PHASE_ROTATOR_ASSERT_SVH
`define SPECTRAL_PHASE_ROTATOR_ASSERT_SVH

// check outside reset
`define SPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check during reset as well
`define SPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/spr_pkg.sv =====
// Shared codes and types of the spectral phase rotator.
// No dependencies.
package spr_pkg;

    localparam logic [2:0] MODE_NORMAL        = 3'd0;
    localparam logic [2:0] MODE_EVEN_ODD      = 3'd1;
    localparam logic [2:0] MODE_HARMONIC      = 3'd2;
    localparam logic [2:0] MODE_HARM_EVEN_ODD = 3'd3;
    localparam logic [2:0] MODE_CLEAR         = 3'd4;

    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_MIX_AMOUNT = 2'd1;
    localparam logic [1:0] REG_STYLE_MODE = 2'd2;

    localparam logic [16:0] MIX_ONE = 17'd65536;

    typedef struct packed {
        logic clip;
        logic clear;
    } spr_flags_t;

endpackage

// ===== rtl/spr_front.sv =====
// Rotation and blend pipeline: index reduction, angle, sine table, products, mix, saturation.
// Depends on spr_pkg. Feeds the square root chain of spr_cell.
module spr_front
    import spr_pkg::*;
#(
    parameter int DATA_WIDTH       = 32,
    parameter int FRAME_BINS       = 2048,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] in_real,
    input  logic signed [DATA_WIDTH-1:0] in_imag,
    input  logic [10:0]                  in_index,
    input  logic [15:0]                  phase_step,
    input  logic [16:0]                  mix_amount,
    input  logic [2:0]                   style_mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [DATA_WIDTH-1:0]        out_real,
    output logic [DATA_WIDTH-1:0]        out_imag,
    output spr_flags_t                   out_flags,
    output logic [2*DATA_WIDTH-1:0]      out_sq
);

    localparam int DW    = DATA_WIDTH;
    localparam int PW    = DW + 16;
    localparam int MW    = DW + 20;
    localparam int AW    = $clog2(SINE_TABLE_DEPTH);
    localparam int RECIP = (1 << 24) / FRAME_BINS + 1;
    localparam logic [23:0] RECIP_W = 24'(RECIP);
    localparam logic [16:0] FB_W    = 17'(FRAME_BINS);
    localparam logic [14:0] DEPTH_W = 15'(SINE_TABLE_DEPTH);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [MW-1:0] HI_W = MW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [MW-1:0] LO_W = -HI_W - MW'(1);

    function automatic logic [63:0] div_k(logic [63:0] t, int n, logic odd);
        logic [63:0] r;
        r = t;
        if (odd) begin
            case (n)
                1: r = t / 6;
                2: r = t / 20;
                3: r = t / 42;
                4: r = t / 72;
                5: r = t / 110;
                6: r = t / 156;
                7: r = t / 210;
                8: r = t / 272;
                9: r = t / 342;
                10: r = t / 420;
                11: r = t / 506;
                default: r = t / 600;
            endcase
        end else begin
            case (n)
                1: r = t / 2;
                2: r = t / 12;
                3: r = t / 30;
                4: r = t / 56;
                5: r = t / 90;
                6: r = t / 132;
                7: r = t / 182;
                8: r = t / 240;
                9: r = t / 306;
                10: r = t / 380;
                11: r = t / 462;
                default: r = t / 552;
            endcase
        end
        return r;
    endfunction

    function automatic logic [63:0] series_q30(logic [63:0] x, logic odd);
        logic [63:0]        term;
        logic [63:0]        t;
        logic signed [63:0] sum;
        term = odd ? x : (64'd1 << 30);
        sum  = $signed(term);
        for (int n = 1; n <= 12; n++) begin
            t    = (((term * x) >> 30) * x) >> 30;
            term = div_k(t, n, odd);
            if ((n & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return (sum < 0) ? 64'd0 : $unsigned(sum);
    endfunction

    function automatic logic signed [15:0] rom_entry(int k);
        logic [63:0] u;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] th;
        logic [63:0] v;
        logic [63:0] q;
        u    = 64'(4 * k);
        quad = u / SINE_TABLE_DEPTH;
        rem  = u % SINE_TABLE_DEPTH;
        th   = (HALF_PI_Q30 * rem) / SINE_TABLE_DEPTH;
        v    = series_q30(th, !quad[0]);
        q    = (v + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return (quad >= 64'd2) ? -$signed(16'(q)) : $signed(16'(q));
    endfunction

    function automatic logic [DW-1:0] sat(logic signed [MW-1:0] v);
        if (v > HI_W) begin
            return HI_W[DW-1:0];
        end else if (v < LO_W) begin
            return LO_W[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    logic signed [15:0] rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic signed [15:0] ROMV = rom_entry(k);
        assign rom[k] = ROMV;
    end

    logic [8:1] vld_reg;
    logic [9:1] rdy;

    always_comb begin
        rdy[9] = out_ready;
        for (int k = 8; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = vld_reg[8];

    // stage 1
    logic signed [DW-1:0] x1_reg, y1_reg;
    logic [10:0]          idx1_reg, q1_reg;
    logic [15:0]          step1_reg;
    logic [16:0]          mix1_reg;
    logic [2:0]           mode1_reg;
    logic [34:0]          q_full;
    assign q_full = 35'(in_index) * 35'(RECIP_W);

    // stage 2
    logic signed [DW-1:0] x2_reg, y2_reg;
    logic [10:0]          idx2_reg;
    logic [10:0]          idx2_next;
    logic                 conj2_reg;
    logic [15:0]          step2_reg;
    logic [16:0]          mix2_reg;
    logic [2:0]           mode2_reg;
    logic [27:0]          qfb;
    assign qfb       = 28'(q1_reg) * 28'(FB_W);
    assign idx2_next = idx1_reg - qfb[10:0];

    // stage 3
    logic signed [DW-1:0] x3_reg, y3_reg;
    logic [15:0]          a3_reg;
    logic [15:0]          a3_next;
    logic [26:0]          ang_prod;
    logic                 conj3_reg;
    logic [16:0]          mix3_reg;
    logic [2:0]           mode3_reg;
    assign ang_prod = 27'(idx2_reg) * 27'(step2_reg);
    assign a3_next  = (mode2_reg == MODE_NORMAL || mode2_reg == MODE_EVEN_ODD)
                      ? ang_prod[15:0] : step2_reg;

    // stage 4
    logic signed [DW-1:0] x4_reg, y4_reg;
    logic signed [15:0]   ri4_reg, c4_reg;
    logic [16:0]          mix4_reg;
    logic [2:0]           mode4_reg;
    logic [15:0]          a_cos;
    logic [30:0]          sin_prod, cos_prod;
    logic signed [15:0]   s_val, c_val;
    assign a_cos    = a3_reg + 16'd16384;
    assign sin_prod = 31'(a3_reg) * 31'(DEPTH_W);
    assign cos_prod = 31'(a_cos) * 31'(DEPTH_W);
    assign s_val    = rom[sin_prod[16+AW-1:16]];
    assign c_val    = rom[cos_prod[16+AW-1:16]];

    // stage 5
    logic signed [DW-1:0]   x5_reg, y5_reg;
    logic signed [PW-1:0]   pxc5_reg, pyr5_reg, pxr5_reg, pyc5_reg;
    logic signed [2*DW-1:0] xx5_reg, yy5_reg;
    logic [16:0]            mix5_reg;
    logic [2:0]             mode5_reg;

    // stage 6
    logic signed [DW-1:0]   x6_reg, y6_reg;
    logic signed [DW+1:0]   dre6_reg, dim6_reg;
    logic [2*DW-1:0]        sq6_reg;
    logic [16:0]            mix6_reg;
    logic [2:0]             mode6_reg;
    logic signed [PW:0]     sre, sim, rre, rim;
    assign sre = (PW+1)'(pxc5_reg) - (PW+1)'(pyr5_reg) + (PW+1)'(16384);
    assign sim = (PW+1)'(pxr5_reg) + (PW+1)'(pyc5_reg) + (PW+1)'(16384);
    assign rre = sre >>> 15;
    assign rim = sim >>> 15;

    // stage 7
    logic signed [DW-1:0]   x7_reg, y7_reg;
    logic signed [MW-1:0]   pre7_reg, pim7_reg;
    logic [2*DW-1:0]        sq7_reg;
    logic [2:0]             mode7_reg;
    logic signed [17:0]     mix_s;
    assign mix_s = $signed({1'b0, mix6_reg});

    // stage 8
    logic [DW-1:0]          re8_reg, im8_reg;
    spr_flags_t             flags8_reg;
    logic [2*DW-1:0]        sq8_reg;
    logic signed [MW-1:0]   ore, oim;
    logic                   rotating;
    assign ore = MW'(x7_reg) + ((pre7_reg + MW'(32768)) >>> 16);
    assign oim = MW'(y7_reg) + ((pim7_reg + MW'(32768)) >>> 16);
    assign rotating = mode7_reg == MODE_NORMAL || mode7_reg == MODE_EVEN_ODD ||
                      mode7_reg == MODE_HARMONIC || mode7_reg == MODE_HARM_EVEN_ODD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 8; k >= 2; k--) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (rdy[1]) begin
                vld_reg[1] <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            x1_reg    <= in_real;
            y1_reg    <= in_imag;
            idx1_reg  <= in_index;
            q1_reg    <= q_full[34:24];
            step1_reg <= phase_step;
            mix1_reg  <= (mix_amount > MIX_ONE) ? MIX_ONE : mix_amount;
            mode1_reg <= style_mode;
        end
        if (rdy[2]) begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            idx2_reg  <= idx2_next;
            conj2_reg <= (mode1_reg == MODE_EVEN_ODD || mode1_reg == MODE_HARM_EVEN_ODD)
                         && idx2_next[0];
            step2_reg <= step1_reg;
            mix2_reg  <= mix1_reg;
            mode2_reg <= mode1_reg;
        end
        if (rdy[3]) begin
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            a3_reg    <= a3_next;
            conj3_reg <= conj2_reg;
            mix3_reg  <= mix2_reg;
            mode3_reg <= mode2_reg;
        end
        if (rdy[4]) begin
            x4_reg    <= x3_reg;
            y4_reg    <= y3_reg;
            ri4_reg   <= conj3_reg ? s_val : -s_val;
            c4_reg    <= c_val;
            mix4_reg  <= mix3_reg;
            mode4_reg <= mode3_reg;
        end
        if (rdy[5]) begin
            x5_reg    <= x4_reg;
            y5_reg    <= y4_reg;
            pxc5_reg  <= PW'(x4_reg) * PW'(c4_reg);
            pyr5_reg  <= PW'(y4_reg) * PW'(ri4_reg);
            pxr5_reg  <= PW'(x4_reg) * PW'(ri4_reg);
            pyc5_reg  <= PW'(y4_reg) * PW'(c4_reg);
            xx5_reg   <= (2*DW)'(x4_reg) * (2*DW)'(x4_reg);
            yy5_reg   <= (2*DW)'(y4_reg) * (2*DW)'(y4_reg);
            mix5_reg  <= mix4_reg;
            mode5_reg <= mode4_reg;
        end
        if (rdy[6]) begin
            x6_reg    <= x5_reg;
            y6_reg    <= y5_reg;
            dre6_reg  <= (DW+2)'(rre) - (DW+2)'(x5_reg);
            dim6_reg  <= (DW+2)'(rim) - (DW+2)'(y5_reg);
            sq6_reg   <= $unsigned(xx5_reg) + $unsigned(yy5_reg);
            mix6_reg  <= mix5_reg;
            mode6_reg <= mode5_reg;
        end
        if (rdy[7]) begin
            x7_reg    <= x6_reg;
            y7_reg    <= y6_reg;
            pre7_reg  <= MW'(dre6_reg) * MW'(mix_s);
            pim7_reg  <= MW'(dim6_reg) * MW'(mix_s);
            sq7_reg   <= sq6_reg;
            mode7_reg <= mode6_reg;
        end
        if (rdy[8]) begin
            sq8_reg          <= sq7_reg;
            flags8_reg.clear <= (mode7_reg == MODE_CLEAR);
            if (rotating) begin
                re8_reg         <= sat(ore);
                im8_reg         <= sat(oim);
                flags8_reg.clip <= (ore > HI_W) || (ore < LO_W) ||
                                   (oim > HI_W) || (oim < LO_W);
            end else begin
                re8_reg         <= x7_reg;
                im8_reg         <= y7_reg;
                flags8_reg.clip <= 1'b0;
            end
        end
    end

    assign out_real  = re8_reg;
    assign out_imag  = im8_reg;
    assign out_flags = flags8_reg;
    assign out_sq    = sq8_reg;

endmodule

// ===== rtl/spr_cell.sv =====
// One cell of the square root chain: settles one root bit and hands on to its neighbor.
// Depends on nothing but its parameters; instantiated in a row by the top level.
module spr_cell #(
    parameter int NB = 32,
    parameter int PW = 66
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2*NB-1:0] in_rad,
    input  logic [NB+1:0]   in_rem,
    input  logic [NB-1:0]   in_root,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2*NB-1:0] out_rad,
    output logic [NB+1:0]   out_rem,
    output logic [NB-1:0]   out_root,
    output logic [PW-1:0]   out_pay
);

    logic            vld_reg;
    logic [2*NB-1:0] rad_reg;
    logic [NB+1:0]   rem_reg;
    logic [NB+1:0]   rem_next;
    logic [NB-1:0]   root_reg;
    logic [PW-1:0]   pay_reg;
    logic [NB+1:0]   rem_in;
    logic [NB+1:0]   trial;
    logic            ge;

    assign in_ready = !vld_reg || out_ready;
    assign rem_in   = {in_rem[NB-1:0], in_rad[2*NB-1 -: 2]};
    assign trial    = {in_root, 2'b01};
    assign ge       = rem_in >= trial;
    assign rem_next = ge ? rem_in - trial : rem_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            rad_reg  <= in_rad << 2;
            rem_reg  <= rem_next;
            root_reg <= {in_root[NB-2:0], ge};
            pay_reg  <= in_pay;
        end
    end

    assign out_valid = vld_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_pay   = pay_reg;

endmodule

// ===== rtl/spectral_phase_rotator.sv =====
// Spectral phase rotator top level: stream ports, register file, sqrt cell row, output stage.
// Depends on spr_pkg, spr_front, spr_cell and spectral_phase_rotator_assert.svh.
//
// One complex bin with its harmonic index enters per beat on the s_axis channel and one
// processed bin leaves per beat on the m_axis channel, in order. The bin is rotated by a
// phasor from an internal sine table and blended with the original by mix_amount; clear
// style returns the magnitude instead. clipped travels on m_axis_tuser.
// Registers sit on the APB port: phase_step at 0x0, mix_amount at 0x4, style_mode at 0x8.
// The path holds eight rotation and blend stages, one square root cell per result bit
// and the output register. Style codes 5 to 7 pass the bin unchanged.
// Throughput is one beat per cycle while the receiver keeps m_axis_tready high.
// Every stage holds its own valid bit, so the input keeps being taken while any stage is
// empty, also while a finished beat waits on m_axis_tready. When all stages are full and
// the receiver stalls, s_axis_tready drops and every stage holds.
// Reset empties all stages and loads phase_step 0, mix_amount 65536, style_mode 0.
`include "spectral_phase_rotator_assert.svh"
module spectral_phase_rotator
    import spr_pkg::*;
#(
    parameter int FRAME_BINS       = 2048,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int DATA_WIDTH       = 32
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_axis_tvalid,
    output logic                                       s_axis_tready,
    // bin_real, bin_imag, bin_index, zero fill
    input  logic [((2*DATA_WIDTH+11+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  logic                                       m_axis_tready,
    // out_real, out_imag, zero fill
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
    // clipped
    output logic                                       m_axis_tuser,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [3:0]                                 paddr,
    input  logic [31:0]                                pwdata,
    output logic [31:0]                                prdata,
    output logic                                       pready
);

    localparam int DW    = DATA_WIDTH;
    localparam int NB    = DATA_WIDTH;
    localparam int PW    = 2*DATA_WIDTH + 2;
    localparam int OUT_W = ((2*DATA_WIDTH+7)/8)*8;
    localparam logic [DW:0] HI_W = (DW+1)'({1'b0, {(DW-1){1'b1}}});

    logic [15:0] phase_step_reg;
    logic [16:0] mix_amount_reg;
    logic [2:0]  style_mode_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= '0;
            mix_amount_reg <= MIX_ONE;
            style_mode_reg <= MODE_NORMAL;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_PHASE_STEP: phase_step_reg <= pwdata[15:0];
                REG_MIX_AMOUNT: mix_amount_reg <= pwdata[16:0];
                REG_STYLE_MODE: style_mode_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PHASE_STEP: prdata = {16'd0, phase_step_reg};
            REG_MIX_AMOUNT: prdata = {15'd0, mix_amount_reg};
            REG_STYLE_MODE: prdata = {29'd0, style_mode_reg};
            default:        prdata = '0;
        endcase
    end

    logic            f_valid, f_ready;
    logic [DW-1:0]   f_real, f_imag;
    spr_flags_t      f_flags;
    logic [2*DW-1:0] f_sq;

    spr_front #(
        .DATA_WIDTH       (DATA_WIDTH),
        .FRAME_BINS       (FRAME_BINS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_real    (s_axis_tdata[DW-1:0]),
        .in_imag    (s_axis_tdata[2*DW-1:DW]),
        .in_index   (s_axis_tdata[2*DW+10:2*DW]),
        .phase_step (phase_step_reg),
        .mix_amount (mix_amount_reg),
        .style_mode (style_mode_reg),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_real   (f_real),
        .out_imag   (f_imag),
        .out_flags  (f_flags),
        .out_sq     (f_sq)
    );

    logic            c_valid [NB+1];
    logic            c_ready [NB+1];
    logic [2*NB-1:0] c_rad   [NB+1];
    logic [NB+1:0]   c_rem   [NB+1];
    logic [NB-1:0]   c_root  [NB+1];
    logic [PW-1:0]   c_pay   [NB+1];

    assign c_valid[0] = f_valid;
    assign f_ready    = c_ready[0];
    assign c_rad[0]   = f_sq;
    assign c_rem[0]   = '0;
    assign c_root[0]  = '0;
    assign c_pay[0]   = {f_flags, f_imag, f_real};

    for (genvar i = 0; i < NB; i++) begin : g_cell
        spr_cell #(
            .NB (NB),
            .PW (PW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_rad    (c_rad[i]),
            .in_rem    (c_rem[i]),
            .in_root   (c_root[i]),
            .in_pay    (c_pay[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_rad   (c_rad[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_root  (c_root[i+1]),
            .out_pay   (c_pay[i+1])
        );
    end

    logic            m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;
    logic            m_clip_reg;
    logic            o_ready;
    logic [DW:0]     mag;
    spr_flags_t      last_flags;
    logic [DW-1:0]   last_real, last_imag;

    assign o_ready       = !m_valid_reg || m_axis_tready;
    assign c_ready[NB]   = o_ready;
    assign last_real     = c_pay[NB][DW-1:0];
    assign last_imag     = c_pay[NB][2*DW-1:DW];
    assign last_flags    = c_pay[NB][PW-1:2*DW];
    assign mag           = (DW+1)'(c_root[NB]) +
                           (DW+1)'(c_rem[NB] > (NB+2)'(c_root[NB]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_ready) begin
            m_valid_reg <= c_valid[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (o_ready) begin
            if (last_flags.clear) begin
                m_data_reg <= OUT_W'({{DW{1'b0}}, (mag > HI_W) ? HI_W[DW-1:0] : mag[DW-1:0]});
                m_clip_reg <= mag > HI_W;
            end else begin
                m_data_reg <= OUT_W'({last_imag, last_real});
                m_clip_reg <= last_flags.clip;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_clip_reg;

    `SPR_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_axis_tvalid, "output valid after reset")
    `SPR_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")
    `SPR_ASSERT(a_clip_on_rail,
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[DW-1:0] == HI_W[DW-1:0] ||
            m_axis_tdata[DW-1:0] == ~HI_W[DW-1:0] ||
            m_axis_tdata[2*DW-1:DW] == HI_W[DW-1:0] ||
            m_axis_tdata[2*DW-1:DW] == ~HI_W[DW-1:0],
        "clip flag without saturated part")

endmodule

// ===== dv/spectral_phase_rotator_tb.sv =====
// Self-checking testbench for spectral_phase_rotator: stream bins in, predict each rotated,
// blended or magnitude result in a local model, and compare every m_axis beat in order.
// Depends on spr_pkg and the spectral_phase_rotator RTL.
module spectral_phase_rotator_tb;
    import spr_pkg::*;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        clip;
    } bin_result_t;

    localparam longint HALF_PI_Q30 = 64'd1686629713;
    localparam longint SAT_HI      = 64'sd2147483647;
    localparam longint SAT_LO      = -64'sd2147483648;
    localparam logic [3:0] ADDR_UNUSED = 4'hC;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // bin_real, bin_imag, bin_index, zero fill
    logic [79:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_real, out_imag
    logic [63:0] m_axis_tdata;
    // clipped
    logic        m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          sine_q15 [1024];
    logic [15:0] cur_step = 16'd0;
    logic [16:0] cur_mix  = MIX_ONE;
    logic [2:0]  cur_mode = MODE_NORMAL;

    bin_result_t pending_bins[$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          stall_cycle = 0;

    spectral_phase_rotator dut (.*);

    always #5 aclk = ~aclk;

    // sine table, Q1.15, one full turn
    function automatic void build_sine_table();
        longint unsigned u, quad, rem, th, term, t, k, sum_u;
        longint          sum;
        int              q;
        for (int i = 0; i < 1024; i++) begin
            u = 64'(4 * i);
            quad = u / 1024;
            rem = u % 1024;
            th = (HALF_PI_Q30 * rem) / 1024;
            term = quad[0] ? 64'd1 << 30 : th;
            sum = term;
            for (int n = 1; n <= 12; n++) begin
                k = quad[0] ? 64'((2*n - 1) * (2*n)) : 64'((2*n) * (2*n + 1));
                t = (((term * th) >> 30) * th) >> 30;
                term = t / k;
                sum = (n & 1) ? sum - longint'(term) : sum + longint'(term);
            end
            sum_u = sum < 0 ? 0 : sum;
            q = int'((sum_u + 16384) >> 15);
            if (q > 32767) q = 32767;
            sine_q15[i] = quad >= 2 ? -q : q;
        end
    endfunction

    function automatic longint clamp32(longint v, ref logic clip);
        if (v > SAT_HI) begin
            clip = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            clip = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    function automatic longint blend_part(longint orig, longint rot, longint m);
        longint d, dh, dl;
        d = rot - orig;
        dh = d >>> 16;
        dl = d - dh * 65536;
        return orig + m * dh + ((m * dl + 32768) >> 16);
    endfunction

    function automatic longint bin_magnitude(longint x, longint y);
        logic [127:0] sq, cand, qq;
        logic [63:0]  ax, ay, root;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        sq = 128'(ax) * ax + 128'(ay) * ay;
        root = '0;
        for (int b = 49; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sq) root = cand[63:0];
        end
        qq = 128'(root) * root + root;
        if (sq > qq) root++;
        return longint'(root);
    endfunction

    function automatic bin_result_t rotate_bin(logic [31:0] re_in, logic [31:0] im_in,
                                               logic [10:0] idx);
        bin_result_t r;
        longint      x, y, s, c, ri, rr, rim, m, ore, oim;
        int          prod;
        logic [15:0] ang, cos_ang;
        logic        conj, clip;
        x = longint'(signed'(re_in));
        y = longint'(signed'(im_in));
        clip = 1'b0;
        if (cur_mode <= MODE_HARM_EVEN_ODD) begin
            prod = int'(idx) * int'(cur_step);
            ang = cur_mode <= MODE_EVEN_ODD ? prod[15:0] : cur_step;
            conj = (cur_mode == MODE_EVEN_ODD || cur_mode == MODE_HARM_EVEN_ODD) && idx[0];
            cos_ang = ang + 16'd16384;
            s = longint'(sine_q15[ang >> 6]);
            c = longint'(sine_q15[cos_ang >> 6]);
            ri = conj ? s : -s;
            rr = (x * c - y * ri + 16384) >>> 15;
            rim = (x * ri + y * c + 16384) >>> 15;
            m = cur_mix > MIX_ONE ? 64'sd65536 : longint'(cur_mix);
            ore = clamp32(blend_part(x, rr, m), clip);
            oim = clamp32(blend_part(y, rim, m), clip);
        end else if (cur_mode == MODE_CLEAR) begin
            ore = clamp32(bin_magnitude(x, y), clip);
            oim = 0;
        end else begin
            ore = x;
            oim = y;
        end
        r.re = ore[31:0];
        r.im = oim[31:0];
        r.clip = clip;
        return r;
    endfunction

    task automatic write_reg(logic [3:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (addr)
            {REG_PHASE_STEP, 2'b00}: cur_step = value[15:0];
            {REG_MIX_AMOUNT, 2'b00}: cur_mix = value[16:0];
            {REG_STYLE_MODE, 2'b00}: cur_mode = value[2:0];
            default: ;
        endcase
    endtask

    task automatic set_rotation(logic [15:0] step, logic [16:0] mix, logic [2:0] mode);
        write_reg({REG_PHASE_STEP, 2'b00}, {16'd0, step});
        write_reg({REG_MIX_AMOUNT, 2'b00}, {15'd0, mix});
        write_reg({REG_STYLE_MODE, 2'b00}, {29'd0, mode});
    endtask

    // hold input until every result is back, then let the pipeline empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_bins.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic send_bin(logic [31:0] re, logic [31:0] im, logic [10:0] idx);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, idx, im, re};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_bins.push_back(rotate_bin(re, im, idx));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(0, 200)) - 32'd100;
            4: return 32'($urandom_range(0, 1 << 20)) - 32'd524288;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_bin(32'd1000, 32'd0, 11'd0);
        send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 11'd2047);
        send_bin(32'h8000_0000, 32'h8000_0000, 11'd1);
        drain();
    endtask

    task automatic test_directed_styles();
        for (int mode = 0; mode < 8; mode++) begin
            set_rotation(16'h2345, MIX_ONE, 3'(mode));
            send_bin(32'h7FFF_FFFF, 32'h8000_0000, 11'd2047);
            send_bin(32'h8000_0000, 32'h7FFF_FFFF, 11'd1);
            send_bin(32'd123456, -32'd654321, 11'd2);
            drain();
        end
        write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
    endtask

    task automatic test_register_extremes();
        set_rotation(16'hFFFF, 17'd0, MODE_NORMAL);
        send_bin(32'h8000_0000, 32'h7FFF_FFFF, 11'd5);
        drain();
        set_rotation(16'h8000, 17'h1FFFF, MODE_HARMONIC);
        send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 11'd0);
        drain();
        set_rotation(16'h0000, 17'd32768, MODE_EVEN_ODD);
        send_bin(32'h8000_0000, 32'h8000_0000, 11'd3);
        drain();
    endtask

    task automatic test_random_bins();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: set_rotation(16'hFFFF, MIX_ONE, MODE_NORMAL);
                1: set_rotation(16'd0, 17'd0, MODE_EVEN_ODD);
                2: set_rotation(16'($urandom), 17'h1FFFF, MODE_HARMONIC);
                3: set_rotation(16'($urandom), 17'($urandom_range(0, 65536)),
                                MODE_HARM_EVEN_ODD);
                4: set_rotation(16'($urandom), 17'($urandom), MODE_CLEAR);
                5: set_rotation(16'($urandom), 17'($urandom), 3'($urandom_range(5, 7)));
                default: set_rotation(16'($urandom), 17'($urandom_range(0, 70000)),
                                      3'($urandom_range(0, 4)));
            endcase
            for (int i = 0; i < 200; i++) begin
                send_bin(pick_word(), pick_word(), 11'($urandom));
                if (phase == 6 && i == 100) drain();
            end
            drain();
        end
    endtask

    // receiver: ready always, random, rare stalls, mostly stalled
    always @(posedge aclk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 700) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= $urandom_range(0, 7) != 0;
            default: m_axis_tready <= $urandom_range(0, 3) == 0;
        endcase
    end

    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
            end else begin
                want = pending_bins.pop_front();
                if (m_axis_tdata[31:0] !== want.re || m_axis_tdata[63:32] !== want.im ||
                    m_axis_tuser !== want.clip) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp re %h im %h clip %b, got re %h im %h clip %b",
                                 want.re, want.im, want.clip, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tuser);
                end
            end
        end
    end

    initial begin
        build_sine_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_styles();
        test_register_extremes();
        test_random_bins();
        if (mismatches == 0 && pending_bins.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== spectral_phase_rotator.f =====
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_front.sv
rtl/spr_cell.sv
rtl/spectral_phase_rotator.sv
dv/spectral_phase_rotator_tb.sv
